// File: design/page_frame_free_list_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// Page frame allocator assertion macros
// Concurrent check wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PFFLA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pffla: same-cycle check failed");
// next-cycle implication
`define PFFLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pffla: next-cycle check failed");
`else
`define PFFLA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PFFLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: design/pffla_pkg.sv
// ----------------------------------------------------------------------------
// Page frame allocator package
// Beat types, codes and shared constants.
// ----------------------------------------------------------------------------
package pffla_pkg;

    localparam int PAGES_DEF = 4096;
    localparam int PAGE_W    = 12;
    localparam int CNT_W     = 13;
    localparam int REG_IDX_W = 1;

    // request kinds
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;
    localparam logic [1:0] KIND_BUILD = 2'd3;

    // result status
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_REJECT = 2'd2;

    // per-page marks
    localparam logic [1:0] MARK_FREE  = 2'd0;
    localparam logic [1:0] MARK_ALLOC = 2'd1;
    localparam logic [1:0] MARK_BAD   = 2'd2;
    localparam logic [1:0] MARK_SYS   = 2'd3;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_PAGE_COUNT   = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SYSTEM_PAGES = 1'b1;

    typedef struct packed {
        logic [1:0]        kind;
        logic [PAGE_W-1:0] page;
    } in_item_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page_out;
        logic [1:0]        status;
        logic [CNT_W-1:0]  free_count;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic walk_step;
        logic finish;
        logic clear_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic walk_done;
        logic out_free;
    } dp_stat_t;

endpackage

// File: design/pffla_dp.sv
// ----------------------------------------------------------------------------
// Page frame allocator datapath
// Mark and link memories, list head, free counter, build walker, result reg.
// ----------------------------------------------------------------------------
module pffla_dp #(
    parameter int PAGES = pffla_pkg::PAGES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [pffla_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [pffla_pkg::CNT_W-1:0]       cfg_wdata,
    input  pffla_pkg::in_item_t               s_data,
    input  logic                              m_ready,
    input  pffla_pkg::ctrl_cmd_t              cmd,
    output pffla_pkg::dp_stat_t               stat,
    output logic                              m_valid,
    output pffla_pkg::out_item_t              m_data
);

    localparam int AW      = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CNT_MAX = (1 << pffla_pkg::CNT_W) - 1;
    localparam int PCAP    = (PAGES < CNT_MAX) ? PAGES : CNT_MAX;
    localparam int CNT_RST = (PAGES < (1 << pffla_pkg::PAGE_W)) ? PAGES
                                                                 : (1 << pffla_pkg::PAGE_W);
    localparam int CW      = pffla_pkg::CNT_W;

    logic [1:0]    marks_mem [PAGES];
    logic [AW-1:0] link_mem  [PAGES];

    logic [CW-1:0] page_count_reg, sys_pages_reg;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] free_reg, free_next;
    logic [CW-1:0] walk_reg, walk_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] pend_p_reg, pend_p_next;
    logic [1:0]    kind_reg, kind_next;
    logic [pffla_pkg::PAGE_W-1:0] page_reg, page_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          m_valid_reg;
    pffla_pkg::out_item_t m_data_reg, res;
    logic          load;

    logic          mk_we, mk_re, ln_we, ln_re;
    logic [AW-1:0] mk_waddr, mk_raddr, ln_waddr, ln_raddr;
    logic [1:0]    mk_wdata, mk_rdata_reg;
    logic [AW-1:0] ln_wdata, ln_rdata_reg;

    logic [CW-1:0] limit;
    logic          in_range;
    logic [AW-1:0] page_idx, pend_idx;

    assign limit    = (page_count_reg < CW'(PCAP)) ? page_count_reg : CW'(PCAP);
    assign in_range = {1'b0, page_reg} < limit;
    assign page_idx = AW'(page_reg);
    assign pend_idx = AW'(pend_p_reg);
    assign ln_raddr = head_reg;

    assign stat.clear_last = (clr_reg == AW'(PAGES - 1));
    assign stat.walk_done  = !pend_reg && (walk_reg >= limit);
    assign stat.out_free   = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        head_next   = head_reg;
        free_next   = free_reg;
        walk_next   = walk_reg;
        pend_next   = pend_reg;
        pend_p_next = pend_p_reg;
        kind_next   = kind_reg;
        page_next   = page_reg;
        clr_next    = clr_reg;
        mk_we       = 1'b0;
        mk_waddr    = page_idx;
        mk_wdata    = pffla_pkg::MARK_FREE;
        mk_re       = 1'b0;
        mk_raddr    = AW'(s_data.page);
        ln_we       = 1'b0;
        ln_waddr    = page_idx;
        ln_wdata    = head_reg;
        ln_re       = 1'b0;
        load        = 1'b0;
        res.page_out = '0;
        res.status   = pffla_pkg::STAT_OK;

        if (cmd.clear_step) begin
            mk_we    = 1'b1;
            mk_waddr = clr_reg;
            clr_next = clr_reg + AW'(1);
        end

        if (cmd.accept) begin
            kind_next = s_data.kind;
            page_next = s_data.page;
            mk_re     = 1'b1;
            ln_re     = 1'b1;
            if (s_data.kind == pffla_pkg::KIND_BUILD) begin
                head_next = '0;
                free_next = '0;
                walk_next = '0;
                pend_next = 1'b0;
            end
        end

        if (cmd.exec) begin
            load = 1'b1;
            case (kind_reg)
                pffla_pkg::KIND_ALLOC: begin
                    if (free_reg == '0) begin
                        res.status = pffla_pkg::STAT_EMPTY;
                    end else begin
                        mk_we        = 1'b1;
                        mk_waddr     = head_reg;
                        mk_wdata     = pffla_pkg::MARK_ALLOC;
                        head_next    = ln_rdata_reg;
                        free_next    = free_reg - CW'(1);
                        res.page_out = pffla_pkg::PAGE_W'(head_reg);
                    end
                end
                pffla_pkg::KIND_FREE: begin
                    if (!in_range || mk_rdata_reg != pffla_pkg::MARK_ALLOC) begin
                        res.status = pffla_pkg::STAT_REJECT;
                    end else begin
                        mk_we     = 1'b1;
                        ln_we     = 1'b1;
                        head_next = page_idx;
                        free_next = free_reg + CW'(1);
                    end
                end
                pffla_pkg::KIND_BAD: begin
                    if (!in_range) begin
                        res.status = pffla_pkg::STAT_REJECT;
                    end else begin
                        mk_we    = 1'b1;
                        mk_wdata = pffla_pkg::MARK_BAD;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.walk_step) begin
            // read page walk_reg, settle the page read by the previous walk step
            if (walk_reg < limit) begin
                mk_re       = 1'b1;
                mk_raddr    = AW'(walk_reg);
                pend_next   = 1'b1;
                pend_p_next = walk_reg;
                walk_next   = walk_reg + CW'(1);
            end else begin
                pend_next = 1'b0;
            end
            if (pend_reg && mk_rdata_reg != pffla_pkg::MARK_BAD) begin
                mk_we    = 1'b1;
                mk_waddr = pend_idx;
                if (pend_p_reg < sys_pages_reg) begin
                    mk_wdata = pffla_pkg::MARK_SYS;
                end else begin
                    ln_we     = 1'b1;
                    ln_waddr  = pend_idx;
                    head_next = pend_idx;
                    free_next = free_reg + CW'(1);
                end
            end
        end

        if (cmd.finish) begin
            load = 1'b1;
        end

        res.free_count = free_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_count_reg <= CW'(CNT_RST);
            sys_pages_reg  <= '0;
            head_reg       <= '0;
            free_reg       <= '0;
            walk_reg       <= '0;
            pend_reg       <= 1'b0;
            clr_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    pffla_pkg::REG_PAGE_COUNT:   page_count_reg <= cfg_wdata;
                    pffla_pkg::REG_SYSTEM_PAGES: sys_pages_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            head_reg <= head_next;
            free_reg <= free_next;
            walk_reg <= walk_next;
            pend_reg <= pend_next;
            clr_reg  <= clr_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_p_reg <= pend_p_next;
        kind_reg   <= kind_next;
        page_reg   <= page_next;
        if (load) begin
            m_data_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (mk_we) begin
            marks_mem[mk_waddr] <= mk_wdata;
        end
        if (mk_re) begin
            mk_rdata_reg <= marks_mem[mk_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ln_we) begin
            link_mem[ln_waddr] <= ln_wdata;
        end
        if (ln_re) begin
            ln_rdata_reg <= link_mem[ln_raddr];
        end
    end

endmodule

// File: design/pffla_ctrl.sv
// ----------------------------------------------------------------------------
// Page frame allocator controller
// Sequences clearing, single requests and the list build walk.
// ----------------------------------------------------------------------------
module pffla_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [1:0]           s_kind,
    input  pffla_pkg::dp_stat_t  stat,
    output logic                 s_ready,
    output pffla_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    assign s_ready = ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = (s_kind == pffla_pkg::KIND_BUILD) ? S_WALK : S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WALK: begin
                cmd.walk_step = 1'b1;
                if (stat.walk_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

endmodule

// File: design/page_frame_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// Page frame free list allocator
// Alloc, free, mark bad: accept with memory read, then execute with write-back
// on the mark and link memories, held while the result slot is full; the
// result is valid in the cycle after execute. Build: a walk of one page per
// cycle through the mark read port, then a finish step that loads the result;
// the next beat is taken after it. Reset: synchronous; a clearing pass zeroes
// the page marks before the first beat; config writes are taken throughout.
// ----------------------------------------------------------------------------
`include "page_frame_free_list_allocator_unit_defines.svh"

module page_frame_free_list_allocator_unit #(
    parameter int PAGES = pffla_pkg::PAGES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [pffla_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [pffla_pkg::CNT_W-1:0]     cfg_wdata,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  pffla_pkg::in_item_t             s_data,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output pffla_pkg::out_item_t            m_data
);

    // Controller/datapath split. The controller only issues one-hot style
    // commands; the datapath reports clear, walk and output-slot status.
    pffla_pkg::ctrl_cmd_t cmd;
    pffla_pkg::dp_stat_t  stat;

    // check terms for the result beat
    logic res_empty, res_reject, empty_clean;

    assign res_empty   = m_valid && (m_data.status == pffla_pkg::STAT_EMPTY);
    assign res_reject  = m_valid && (m_data.status == pffla_pkg::STAT_REJECT);
    assign empty_clean = (m_data.page_out == '0) && (m_data.free_count == '0);

    pffla_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .stat    (stat),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    // Datapath owns both memories. The result register decouples the
    // request side: a new beat is accepted while a result is still waiting,
    // and execution stalls only when it needs the occupied result slot.
    pffla_dp #(
        .PAGES (PAGES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    // An empty alloc reports no page and an empty list.
    `PFFLA_ASSERT_IMPL(a_empty_zero, aclk, aresetn, res_empty, empty_clean)
    // A rejected request never hands out a page.
    `PFFLA_ASSERT_IMPL(a_reject_nopage, aclk, aresetn, res_reject, m_data.page_out == '0)
    // One beat in flight at a time: accept drops ready for the next cycle.
    `PFFLA_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

// File: bench/page_frame_free_list_allocator_unit_test.sv
// ----------------------------------------------------------------------------
// Page frame allocator testbench
// Drives alloc, free, mark-bad and build requests through the valid/ready
// request channel and checks every result beat against an in-bench model of
// the LIFO free list, across several page count and reserved-page settings.
// ----------------------------------------------------------------------------
module page_frame_free_list_allocator_unit_test;

    import pffla_pkg::*;

    localparam int PAGES          = PAGES_DEF;
    localparam int CLK_HALF       = 6;
    localparam int BACKLOG        = 4;        // requests queued ahead of the driver
    localparam int SETTLE_CYCLES  = 8;        // result lands in the cycle after execute
    localparam int TIMEOUT_CYCLES = 800_000;  // far above the slowest legal run

    // receiver stall patterns
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_BLINK
    } rdy_mode_t;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_wdata = '0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_data;

    page_frame_free_list_allocator_unit #(
        .PAGES(PAGES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Allocator model: register copies, marks, link words, list head, count.
    // Link words start at zero; they are only ever read after a push.
    // ------------------------------------------------------------------------
    bit [CNT_W-1:0]  cfg_page_count   = CNT_W'(4096);
    bit [CNT_W-1:0]  cfg_system_pages = '0;
    bit [PAGE_W-1:0] link_mem [PAGES];
    bit [1:0]        mark_mem [PAGES];
    bit [PAGE_W-1:0] list_head = '0;
    bit [CNT_W-1:0]  free_cnt  = '0;

    in_item_t        pending_reqs[$];     // stimulus not yet on the bus
    out_item_t       awaited_results[$];  // predicted result beats, oldest first
    bit [PAGE_W-1:0] handed_out[$];       // pages given out by alloc, may be stale
    int unsigned     mismatches = 0;

    function automatic int unsigned managed_pages();
        return (cfg_page_count < PAGES) ? int'(cfg_page_count) : PAGES;
    endfunction

    function automatic void push_frame(bit [PAGE_W-1:0] pg);
        link_mem[pg] = list_head;
        list_head    = pg;
        free_cnt     = free_cnt + 1'b1;
    endfunction

    // Applies one request to the model and returns the beat it must produce.
    function automatic out_item_t allocator_step(in_item_t req);
        out_item_t       res;
        int unsigned     limit;
        bit [PAGE_W-1:0] pg;
        limit      = managed_pages();
        res        = '0;
        res.status = STAT_OK;
        case (req.kind)
            KIND_ALLOC: begin
                if (free_cnt == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    pg           = list_head;
                    list_head    = link_mem[pg];
                    link_mem[pg] = '0;
                    // a bad page still on the list is handed out and relabeled
                    mark_mem[pg] = MARK_ALLOC;
                    free_cnt     = free_cnt - 1'b1;
                    res.page_out = pg;
                    handed_out.push_back(pg);
                end
            end
            KIND_FREE: begin
                if (req.page >= limit || mark_mem[req.page] != MARK_ALLOC) begin
                    res.status = STAT_REJECT;
                end else begin
                    mark_mem[req.page] = MARK_FREE;
                    push_frame(req.page);
                end
            end
            KIND_BAD: begin
                if (req.page >= limit)
                    res.status = STAT_REJECT;
                else
                    mark_mem[req.page] = MARK_BAD;
            end
            KIND_BUILD: begin
                // fresh list; bad marks survive, everything else is relabeled
                list_head = '0;
                free_cnt  = '0;
                for (int unsigned p = 0; p < limit; p++) begin
                    if (mark_mem[p] != MARK_BAD) begin
                        if (p < cfg_system_pages) begin
                            mark_mem[p] = MARK_SYS;
                        end else begin
                            mark_mem[p] = MARK_FREE;
                            push_frame(PAGE_W'(p));
                        end
                    end
                end
            end
        endcase
        res.free_count = free_cnt;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: bursts of random length with random gaps. The model is stepped
    // on the accepting edge, so the expected beat queue follows bus order.
    // ------------------------------------------------------------------------
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_data     <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_valid && s_ready)
                awaited_results.push_back(allocator_step(s_data));
            // only move on once the current beat (if any) has gone
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    s_data  <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        // half the bursts run straight into the next one
                        gap_left   <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: m_ready follows a stall pattern that changes every so often.
    // ------------------------------------------------------------------------
    rdy_mode_t   stall_mode;
    int unsigned mode_left;
    bit [2:0]    tick;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_mode <= RDY_ALWAYS;
            mode_left  <= 0;
            tick       <= '0;
        end else begin
            tick <= tick + 1'b1;
            if (mode_left == 0) begin
                stall_mode <= rdy_mode_t'($urandom_range(0, 3));
                mode_left  <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                RDY_ALWAYS: m_ready <= 1'b1;
                RDY_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                RDY_BLINK:  m_ready <= tick[2];
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: each accepted result beat against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: page_out=%0d status=%0d free_count=%0d",
                             m_data.page_out, m_data.status, m_data.free_count);
            end else begin
                want = awaited_results.pop_front();
                if (m_data.page_out !== want.page_out || m_data.status !== want.status ||
                    m_data.free_count !== want.free_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected page_out=%0d status=%0d ",
                                  "free_count=%0d, got page_out=%0d status=%0d free_count=%0d"},
                                 want.page_out, want.status, want.free_count,
                                 m_data.page_out, m_data.status, m_data.free_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send(logic [1:0] kind, logic [PAGE_W-1:0] pg);
        in_item_t req;
        req.kind = kind;
        req.page = pg;
        while (pending_reqs.size() >= BACKLOG)
            @(negedge aclk);
        pending_reqs.push_back(req);
    endtask

    // sender holds off until every outstanding result has come back
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_valid || awaited_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, int unsigned val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CNT_W'(val);
        if (idx == REG_PAGE_COUNT)
            cfg_page_count = CNT_W'(val);
        else
            cfg_system_pages = CNT_W'(val);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Random request. Most frees target pages the model says are allocated,
    // the rest are stray in-range pages or any 12-bit page.
    function automatic in_item_t next_request(int unsigned build_pct);
        in_item_t        req;
        int unsigned     roll;
        int unsigned     sub;
        int unsigned     limit;
        int unsigned     idx;
        bit [PAGE_W-1:0] pg;
        bit              found;
        limit    = managed_pages();
        req.page = PAGE_W'($urandom_range(0, 4095));
        roll     = $urandom_range(0, 99);
        found    = 1'b0;
        if (roll < build_pct) begin
            req.kind = KIND_BUILD;
        end else if (roll < 52) begin
            req.kind = KIND_ALLOC;
        end else if (roll < 97) begin
            req.kind = KIND_FREE;
            sub      = $urandom_range(0, 9);
            if (sub < 8) begin
                while (!found && handed_out.size() != 0) begin
                    idx = $urandom_range(0, handed_out.size() - 1);
                    pg  = handed_out[idx];
                    handed_out.delete(idx);
                    if (mark_mem[pg] == MARK_ALLOC) begin
                        found    = 1'b1;
                        req.page = pg;
                    end
                end
            end
            if (!found && sub != 9 && limit != 0)
                req.page = PAGE_W'($urandom_range(0, limit - 1));
        end else begin
            req.kind = KIND_BAD;
            if ($urandom_range(0, 4) != 0 && limit != 0)
                req.page = PAGE_W'($urandom_range(0, limit - 1));
        end
        return req;
    endfunction

    // one setting: program both registers, rebuild, then random traffic
    task automatic random_phase(int unsigned pages, int unsigned sys, int unsigned n,
                                int unsigned build_pct);
        in_item_t req;
        wait_idle();
        write_reg(REG_PAGE_COUNT, pages);
        write_reg(REG_SYSTEM_PAGES, sys);
        send(KIND_BUILD, PAGE_W'($urandom_range(0, 4095)));
        for (int unsigned k = 1; k < n; k++) begin
            if (k % 150 == 0)
                wait_idle();
            req = next_request(build_pct);
            send(req.kind, req.page);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, list never built: empty alloc, free of a plain page,
        // mark the top page bad, free of a bad page
        send(KIND_ALLOC, '0);
        send(KIND_FREE, 12'd4095);
        send(KIND_BAD, 12'd4095);
        send(KIND_FREE, 12'd4095);

        // six pages, two reserved: free list is 5,4,3,2
        wait_idle();
        write_reg(REG_PAGE_COUNT, 6);
        write_reg(REG_SYSTEM_PAGES, 2);
        send(KIND_BUILD, 12'd4095);
        send(KIND_FREE, 12'd0);        // reserved
        send(KIND_FREE, 12'd5);        // already free
        send(KIND_FREE, 12'd6);        // past the page count
        send(KIND_BAD, 12'd4095);      // past the page count
        send(KIND_BAD, 12'd5);         // bad while on the list
        repeat (4) send(KIND_ALLOC, '0);  // 5 comes out despite the bad mark
        send(KIND_ALLOC, '0);          // list drained
        send(KIND_FREE, 12'd5);
        send(KIND_FREE, 12'd2);
        send(KIND_BAD, 12'd3);         // allocated page goes bad
        send(KIND_FREE, 12'd3);
        send(KIND_BUILD, '0);          // rebuild reclaims allocated pages
        send(KIND_ALLOC, '0);

        // no pages at all
        wait_idle();
        write_reg(REG_PAGE_COUNT, 0);
        send(KIND_BAD, '0);
        send(KIND_BUILD, '0);
        send(KIND_ALLOC, '0);

        // random traffic; small page counts keep builds cheap and reach empty
        random_phase(16, 3, 250, 2);
        random_phase(1, 0, 60, 3);
        random_phase(40, 0, 250, 2);
        random_phase(8191, 8191, 40, 0);   // every page reserved
        random_phase(4096, 0, 200, 0);
        random_phase(24, 20, 200, 3);
        random_phase(0, 0, 30, 5);
        random_phase(64, 1, 340, 2);

        wait_idle();
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("page_frame_free_list_allocator_unit_test: PASS");
        else
            $display("page_frame_free_list_allocator_unit_test: FAIL");
        $finish;
    end

    // covers the post-reset clearing pass and every full-size build
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("page_frame_free_list_allocator_unit_test: FAIL");
        $finish;
    end

endmodule
